@@ rtl/btm_pkg.sv @@
// Shared constants for the breakpoint table manager.
package btm_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ADDR_W = 24;
	localparam int WORD_W = 16;
	localparam int MODE_W = 3;
	localparam int STAT_W = 3;
	localparam int IDX_W  = 4;

	localparam logic [WORD_W-1:0] ILLEGAL_OPCODE = 16'h4AFC;
	localparam logic [ADDR_W-1:0] VECTOR_RESET   = 24'h000100;

	localparam logic [MODE_W-1:0] MODE_SET         = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR_ALL   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INSTALL_ALL = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RESTORE_ALL = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RESTORE_ONE = 3'd6;
	localparam logic [MODE_W-1:0] MODE_NONE        = 3'd7;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_IN_VECTOR = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_MEMORY = 3'd2;
	localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;

endpackage

@@ rtl/breakpoint_table_manager.sv @@
// Breakpoint table manager: slot memories, scan sequencer and result register.
//
// Usage: commands enter on the cmd channel (cmd_valid / cmd_stall) with mode,
// target_address, memory_present and original_word. Results leave on the rsp
// channel (rsp_valid / rsp_stall); the final result of a command has last set.
// vector_limit is written on the cfg channel (cfg_valid / cfg_ready, always
// ready) and takes effect for the next command.
// Set, clear, search and restore-one scan all slots through the slot memories,
// one slot read per cycle while the receiver does not stall, each read
// registered before its compare. Install-all and restore-all run the same scan
// and emit one write request per occupied slot, at most one per cycle. Clear-all
// and a walk over an empty table skip the scan. Mode 7 is taken and dropped.
// One command is in work at a time; cmd_stall stays high until the sequencer
// is idle again with the last result in the output register, which lets the
// next command in while that result waits.
// A stalled receiver freezes the scan: the result register, the read pipeline
// and the slot index hold until the transaction goes through.
// Reset empties the table through per-slot valid flip-flops and sets
// vector_limit to 0x100; no clearing pass is needed.
module breakpoint_table_manager (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [btm_pkg::ADDR_W-1:0]    vector_limit,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [btm_pkg::MODE_W-1:0]    mode,
	input  logic [btm_pkg::ADDR_W-1:0]    target_address,
	input  logic                          memory_present,
	input  logic [btm_pkg::WORD_W-1:0]    original_word,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [btm_pkg::STAT_W-1:0]    status,
	output logic [btm_pkg::IDX_W-1:0]     slot_index,
	output logic                          write_valid,
	output logic [btm_pkg::ADDR_W-1:0]    write_address,
	output logic [btm_pkg::WORD_W-1:0]    write_data,
	output logic                          last
);
	import btm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	logic [ADDR_W-1:0] addr_mem [SLOTS];
	logic [WORD_W-1:0] word_mem [SLOTS];

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] limit_q;
	logic [SLOTS-1:0]  valid_q;
	logic [MODE_W-1:0] mode_q;
	logic [ADDR_W-1:0] key_q;
	logic              mem_q;
	logic [WORD_W-1:0] word_q;
	logic              inv_q;
	logic              found_q;
	logic [SLOT_W-1:0] fidx_q;
	logic [WORD_W-1:0] fword_q;
	logic              free_q;
	logic [SLOT_W-1:0] free_idx_q;

	logic              rd_act_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic              rv_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              occ_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [WORD_W-1:0] word_s1;

	logic              rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [IDX_W-1:0]  slot_index_q;
	logic              write_valid_q;
	logic [ADDR_W-1:0] write_address_q;
	logic [WORD_W-1:0] write_data_q;
	logic              last_q;

	logic              accept;
	logic              adv;
	logic              walk_q;
	logic [ADDR_W-1:0] key_d;
	logic              hit;
	logic              above;
	logic              fin_fire;
	logic              set_ok;
	logic              mem_we;

	logic [STAT_W-1:0] fin_status;
	logic [IDX_W-1:0]  fin_index;
	logic              fin_wv;
	logic [ADDR_W-1:0] fin_wa;
	logic [WORD_W-1:0] fin_wd;

	assign cfg_ready = 1'b1;
	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign walk_q    = (mode_q == MODE_INSTALL_ALL) || (mode_q == MODE_RESTORE_ALL);
	assign key_d     = (mode == MODE_SET) ? {target_address[ADDR_W-1:1], 1'b0}
	                                      : target_address;
	assign hit       = occ_s1 && (addr_s1 == key_q) && !inv_q;
	assign fin_fire  = (state_q == S_FIN) && adv;
	assign set_ok    = (mode_q == MODE_SET) && !inv_q && mem_q && !found_q && free_q;
	assign mem_we    = fin_fire && set_ok;

	always_comb begin
		above = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (SLOT_W'(j) > idx_s1 && valid_q[j]) begin
				above = 1'b1;
			end
		end
	end

	always_comb begin
		fin_status = ST_OK;
		fin_index  = '0;
		fin_wv     = 1'b0;
		fin_wa     = '0;
		fin_wd     = '0;
		case (mode_q)
			MODE_SET: begin
				if (inv_q) begin
					fin_status = ST_IN_VECTOR;
				end else if (!mem_q) begin
					fin_status = ST_NO_MEMORY;
				end else if (found_q) begin
					fin_status = ST_EXISTS;
				end else if (!free_q) begin
					fin_status = ST_FULL;
				end else begin
					fin_index = IDX_W'(free_idx_q);
				end
			end
			MODE_CLEAR: begin
				if (inv_q) begin
					fin_status = ST_IN_VECTOR;
				end else if (!found_q) begin
					fin_status = ST_NOT_FOUND;
				end else begin
					fin_index = IDX_W'(fidx_q);
				end
			end
			MODE_SEARCH: begin
				if (!found_q) begin
					fin_status = ST_NOT_FOUND;
				end else begin
					fin_index = IDX_W'(fidx_q);
				end
			end
			MODE_RESTORE_ONE: begin
				if (!found_q) begin
					fin_status = ST_NOT_FOUND;
				end else begin
					fin_index = IDX_W'(fidx_q);
					fin_wv    = 1'b1;
					fin_wa    = key_q;
					fin_wd    = fword_q;
				end
			end
			default: begin
				fin_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= VECTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= vector_limit;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			addr_mem[free_idx_q] <= key_q;
			word_mem[free_idx_q] <= word_q;
		end
		if (rd_act_q && adv) begin
			addr_s1 <= addr_mem[rd_idx_q];
			word_s1 <= word_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= key_d;
			mem_q  <= memory_present;
			word_q <= original_word;
			inv_q  <= (key_d == '0) || (key_d < limit_q);
		end
		if (state_q == S_SCAN && rv_s1 && adv) begin
			if (hit && !found_q) begin
				fidx_q  <= idx_s1;
				fword_q <= word_s1;
			end
			if (!occ_s1 && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			rd_act_q <= 1'b0;
			rd_idx_q <= '0;
			rv_s1    <= 1'b0;
			idx_s1   <= '0;
			occ_s1   <= 1'b0;
			found_q  <= 1'b0;
			free_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						free_q  <= 1'b0;
						if (mode == MODE_NONE) begin
							state_q <= S_IDLE;
						end else if (mode == MODE_CLEAR_ALL ||
						             ((mode == MODE_INSTALL_ALL ||
						               mode == MODE_RESTORE_ALL) && valid_q == '0)) begin
							state_q <= S_FIN;
						end else begin
							state_q  <= S_SCAN;
							rd_act_q <= 1'b1;
							rd_idx_q <= '0;
						end
					end
				end
				S_SCAN: begin
					if (adv) begin
						rv_s1  <= rd_act_q;
						idx_s1 <= rd_idx_q;
						occ_s1 <= valid_q[rd_idx_q];
						if (rd_act_q) begin
							if (rd_idx_q == LAST_SLOT) begin
								rd_act_q <= 1'b0;
							end else begin
								rd_idx_q <= rd_idx_q + 1'b1;
							end
						end
						if (rv_s1) begin
							if (hit) begin
								found_q <= 1'b1;
							end
							if (!occ_s1) begin
								free_q <= 1'b1;
							end
							if (idx_s1 == LAST_SLOT) begin
								state_q <= walk_q ? S_IDLE : S_FIN;
							end
						end
					end
				end
				S_FIN: begin
					if (adv) begin
						state_q <= S_IDLE;
						rv_s1   <= 1'b0;
						if (mode_q == MODE_CLEAR_ALL) begin
							valid_q <= '0;
						end else if (set_ok) begin
							valid_q[free_idx_q] <= 1'b1;
						end else if (mode_q == MODE_CLEAR && !inv_q && found_q) begin
							valid_q[fidx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_fire || (state_q == S_SCAN && adv && rv_s1 && walk_q && occ_s1)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && adv && rv_s1 && walk_q && occ_s1) begin
			status_q        <= ST_OK;
			slot_index_q    <= IDX_W'(idx_s1);
			write_valid_q   <= 1'b1;
			write_address_q <= addr_s1;
			write_data_q    <= (mode_q == MODE_INSTALL_ALL) ? ILLEGAL_OPCODE : word_s1;
			last_q          <= !above;
		end else if (fin_fire) begin
			status_q        <= fin_status;
			slot_index_q    <= fin_index;
			write_valid_q   <= fin_wv;
			write_address_q <= fin_wa;
			write_data_q    <= fin_wd;
			last_q          <= 1'b1;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign slot_index    = slot_index_q;
	assign write_valid   = write_valid_q;
	assign write_address = write_address_q;
	assign write_data    = write_data_q;
	assign last          = last_q;

	a_s1_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> state_q == S_SCAN)
		else $error("read pipeline active outside scan");

	a_clear_all_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && mode_q == MODE_CLEAR_ALL |=> valid_q == '0)
		else $error("clear-all left occupied slots");

	a_set_occupies: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(free_idx_q)])
		else $error("set did not occupy its slot");

	a_found_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && found_q |-> valid_q[fidx_q])
		else $error("matched slot is not occupied");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for breakpoint_table_manager: queued commands against a table model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import btm_pkg::*;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] target_address;
		logic              memory_present;
		logic [WORD_W-1:0] original_word;
	} command_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  slot_index;
		logic              write_valid;
		logic [ADDR_W-1:0] write_address;
		logic [WORD_W-1:0] write_data;
		logic              last;
	} reply_t;

	localparam int          POOL_SIZE     = 20;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          SETTLE_CYCLES = 40;
	localparam int unsigned ADDR_MAX      = 32'h00FFFFFF;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              cfg_valid      = 1'b0;
	logic              cfg_ready;
	logic [ADDR_W-1:0] vector_limit   = VECTOR_RESET;
	logic              cmd_valid      = 1'b0;
	logic              cmd_stall;
	logic [MODE_W-1:0] mode           = MODE_NONE;
	logic [ADDR_W-1:0] target_address = '0;
	logic              memory_present = 1'b0;
	logic [WORD_W-1:0] original_word  = '0;
	logic              rsp_valid;
	logic              rsp_stall      = 1'b0;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  slot_index;
	logic              write_valid;
	logic [ADDR_W-1:0] write_address;
	logic [WORD_W-1:0] write_data;
	logic              last;

	command_t          command_queue[$];
	reply_t            pending_replies[$];
	logic [ADDR_W-1:0] bp_addr [SLOTS] = '{default: '0};
	logic [WORD_W-1:0] bp_word [SLOTS] = '{default: '0};
	logic [ADDR_W-1:0] bp_limit = VECTOR_RESET;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE] = '{default: '0};
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	bit                cmd_accepted   = 1'b0;
	bit                hold_request   = 1'b0;
	bit                hold_done      = 1'b0;
	int                hold_count     = 0;
	int                fail_count     = 0;

	breakpoint_table_manager u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.vector_limit   (vector_limit),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.mode           (mode),
		.target_address (target_address),
		.memory_present (memory_present),
		.original_word  (original_word),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.slot_index     (slot_index),
		.write_valid    (write_valid),
		.write_address  (write_address),
		.write_data     (write_data),
		.last           (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit below_limit(input logic [ADDR_W-1:0] a);
		return (a == '0) || (a < bp_limit);
	endfunction

	function automatic int find_slot(input logic [ADDR_W-1:0] a);
		for (int i = 0; i < SLOTS; i++)
			if (bp_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void push_reply(input logic [STAT_W-1:0] st, input int idx,
			input logic wv, input logic [ADDR_W-1:0] wa, input logic [WORD_W-1:0] wd,
			input logic fin);
		reply_t r;
		r.status        = st;
		r.slot_index    = IDX_W'(idx);
		r.write_valid   = wv;
		r.write_address = wa;
		r.write_data    = wd;
		r.last          = fin;
		pending_replies.push_back(r);
	endfunction

	function automatic void run_command(input command_t c);
		logic [ADDR_W-1:0] a;
		int                slot;
		int                occupied;
		int                emitted;
		int                k;
		a    = c.target_address;
		slot = below_limit(a) ? -1 : find_slot(a);
		case (c.mode)
			MODE_SET: begin
				a[0] = 1'b0;
				if (below_limit(a)) begin
					push_reply(ST_IN_VECTOR, 0, 1'b0, '0, '0, 1'b1);
				end else if (!c.memory_present) begin
					push_reply(ST_NO_MEMORY, 0, 1'b0, '0, '0, 1'b1);
				end else if (find_slot(a) >= 0) begin
					push_reply(ST_EXISTS, 0, 1'b0, '0, '0, 1'b1);
				end else begin
					slot = -1;
					for (k = 0; k < SLOTS && slot < 0; k++)
						if (bp_addr[k] == '0)
							slot = k;
					if (slot < 0) begin
						push_reply(ST_FULL, 0, 1'b0, '0, '0, 1'b1);
					end else begin
						bp_addr[slot] = a;
						bp_word[slot] = c.original_word;
						push_reply(ST_OK, slot, 1'b0, '0, '0, 1'b1);
					end
				end
			end
			MODE_CLEAR: begin
				if (below_limit(a)) begin
					push_reply(ST_IN_VECTOR, 0, 1'b0, '0, '0, 1'b1);
				end else if (slot < 0) begin
					push_reply(ST_NOT_FOUND, 0, 1'b0, '0, '0, 1'b1);
				end else begin
					bp_addr[slot] = '0;
					push_reply(ST_OK, slot, 1'b0, '0, '0, 1'b1);
				end
			end
			MODE_SEARCH: begin
				if (slot < 0)
					push_reply(ST_NOT_FOUND, 0, 1'b0, '0, '0, 1'b1);
				else
					push_reply(ST_OK, slot, 1'b0, '0, '0, 1'b1);
			end
			MODE_CLEAR_ALL: begin
				for (k = 0; k < SLOTS; k++)
					bp_addr[k] = '0;
				push_reply(ST_OK, 0, 1'b0, '0, '0, 1'b1);
			end
			MODE_INSTALL_ALL, MODE_RESTORE_ALL: begin
				occupied = 0;
				for (k = 0; k < SLOTS; k++)
					if (bp_addr[k] != '0)
						occupied++;
				if (occupied == 0) begin
					push_reply(ST_OK, 0, 1'b0, '0, '0, 1'b1);
				end else begin
					emitted = 0;
					for (k = 0; k < SLOTS; k++) begin
						if (bp_addr[k] != '0) begin
							emitted++;
							push_reply(ST_OK, k, 1'b1, bp_addr[k],
								(c.mode == MODE_INSTALL_ALL) ? ILLEGAL_OPCODE : bp_word[k],
								emitted == occupied);
						end
					end
				end
			end
			MODE_RESTORE_ONE: begin
				if (slot < 0)
					push_reply(ST_NOT_FOUND, 0, 1'b0, '0, '0, 1'b1);
				else
					push_reply(ST_OK, slot, 1'b1, bp_addr[slot], bp_word[slot], 1'b1);
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				$error("result with nothing pending: status %0h slot_index %0h", status,
					slot_index);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("slot_index", 32'(want.slot_index), 32'(slot_index));
				check_field("write_valid", 32'(want.write_valid), 32'(write_valid));
				check_field("write_address", 32'(want.write_address), 32'(write_address));
				check_field("write_data", 32'(want.write_data), 32'(write_data));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
		if (cmd_valid && !cmd_stall) begin
			run_command(command_t'{mode, target_address, memory_present, original_word});
			command_queue.delete(0);
		end
		cmd_accepted = cmd_valid && !cmd_stall;
		if (cfg_valid && cfg_ready)
			bp_limit = vector_limit;
	end

	always @(negedge clk) begin
		if (!cmd_valid || cmd_accepted) begin
			if (command_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				{mode, target_address, memory_present, original_word} <= command_queue[0];
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_done  = 1'b1;
			hold_count = HOLD_CYCLES;
		end
		if (hold_count > 0) begin
			hold_count--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
		end
	end

	task automatic refresh_pool(input logic [ADDR_W-1:0] lim);
		int unsigned lo;
		int unsigned near_hi;
		lo      = 32'(lim);
		near_hi = (lo + 512 > ADDR_MAX) ? ADDR_MAX : lo + 512;
		addr_pool[0] = lim;
		addr_pool[1] = lim | 24'h000001;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = ADDR_W'((i < 10) ? $urandom_range(near_hi, lo)
			                                : $urandom_range(ADDR_MAX, lo));
	endtask

	task automatic write_limit(input logic [ADDR_W-1:0] value);
		@(negedge clk);
		vector_limit <= value;
		cfg_valid    <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		refresh_pool(value);
	endtask

	task automatic drain();
		while (command_queue.size() != 0 || pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_cmd(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
			input logic mem, input logic [WORD_W-1:0] w);
		command_queue.push_back(command_t'{m, a, mem, w});
	endtask

	function automatic logic [ADDR_W-1:0] pick_address();
		int          r;
		int unsigned lim;
		r   = $urandom_range(99, 0);
		lim = 32'(bp_limit);
		if (r < 60)
			return addr_pool[$urandom_range(POOL_SIZE - 1, 0)];
		if (r < 72 && lim > 1)
			return ADDR_W'($urandom_range(lim - 1, 0));
		if (r < 80)
			return '0;
		return ADDR_W'($urandom);
	endfunction

	function automatic command_t random_command();
		command_t c;
		int       r;
		r                = $urandom_range(99, 0);
		c.target_address = pick_address();
		c.memory_present = ($urandom_range(99, 0) < 85);
		c.original_word  = WORD_W'($urandom);
		if (r < 40)
			c.mode = MODE_SET;
		else if (r < 52)
			c.mode = MODE_CLEAR;
		else if (r < 64)
			c.mode = MODE_SEARCH;
		else if (r < 74)
			c.mode = MODE_RESTORE_ONE;
		else if (r < 80)
			c.mode = MODE_INSTALL_ALL;
		else if (r < 86)
			c.mode = MODE_RESTORE_ALL;
		else if (r < 88)
			c.mode = MODE_CLEAR_ALL;
		else if (r < 91)
			c.mode = MODE_NONE;
		else
			c.mode = MODE_SET;
		return c;
	endfunction

	task automatic queue_fill_burst();
		int unsigned lo;
		lo = (bp_limit < 2) ? 32'd2 : 32'(bp_limit);
		repeat (SLOTS + 1)
			push_cmd(MODE_SET, ADDR_W'($urandom_range(ADDR_MAX, lo)), 1'b1,
				WORD_W'($urandom));
		push_cmd(MODE_INSTALL_ALL, ADDR_W'($urandom), 1'b1, WORD_W'($urandom));
	endtask

	task automatic queue_random(input int n);
		command_t c;
		int       count;
		count = 0;
		while (count < n) begin
			if ($urandom_range(99, 0) < 3) begin
				queue_fill_burst();
				count += SLOTS + 2;
			end else begin
				c = random_command();
				command_queue.push_back(c);
				if (c.mode != MODE_NONE)
					count++;
			end
		end
	endtask

	initial begin
		#2000000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_limit(VECTOR_RESET);

		push_cmd(MODE_SEARCH, 24'h001000, 1'b1, 16'h0000);
		push_cmd(MODE_RESTORE_ALL, 24'h000000, 1'b0, 16'h0000);
		push_cmd(MODE_INSTALL_ALL, 24'hFFFFFF, 1'b1, 16'hFFFF);
		push_cmd(MODE_SET, 24'h000000, 1'b1, 16'h1234);
		push_cmd(MODE_SET, 24'h0000FF, 1'b1, 16'h1234);
		push_cmd(MODE_SET, 24'h000200, 1'b0, 16'h1234);
		push_cmd(MODE_SET, 24'h000101, 1'b1, 16'hFFFF);
		push_cmd(MODE_SET, 24'h000100, 1'b1, 16'h0000);
		push_cmd(MODE_SEARCH, 24'h000101, 1'b0, 16'h0000);
		push_cmd(MODE_SEARCH, 24'h000100, 1'b0, 16'h0000);
		push_cmd(MODE_SET, 24'hFFFFFF, 1'b1, 16'h0000);
		push_cmd(MODE_RESTORE_ONE, 24'hFFFFFE, 1'b0, 16'h0000);
		push_cmd(MODE_RESTORE_ONE, 24'h000080, 1'b0, 16'h0000);
		push_cmd(MODE_CLEAR, 24'h000080, 1'b0, 16'h0000);
		push_cmd(MODE_CLEAR, 24'h000300, 1'b0, 16'h0000);
		push_cmd(MODE_NONE, 24'h000100, 1'b1, 16'hFFFF);
		push_cmd(MODE_INSTALL_ALL, 24'h000000, 1'b0, 16'h0000);
		push_cmd(MODE_RESTORE_ALL, 24'h000000, 1'b0, 16'h0000);
		push_cmd(MODE_CLEAR, 24'h000100, 1'b0, 16'h0000);
		push_cmd(MODE_CLEAR_ALL, 24'h000000, 1'b0, 16'h0000);
		drain();

		queue_fill_burst();
		queue_random(100);
		hold_request = 1'b1;
		drain();

		write_limit('0);
		send_idle_pct  = 88;
		recv_stall_pct = 0;
		push_cmd(MODE_SET, 24'h000000, 1'b1, 16'hA5A5);
		push_cmd(MODE_SET, 24'h000001, 1'b1, 16'h5A5A);
		push_cmd(MODE_SEARCH, 24'h000000, 1'b0, 16'h0000);
		push_cmd(MODE_CLEAR, 24'h000000, 1'b0, 16'h0000);
		push_cmd(MODE_RESTORE_ONE, 24'h000000, 1'b0, 16'h0000);
		queue_random(100);
		drain();

		write_limit(ADDR_W'($urandom_range(32'h0000FFFF, 32'h00000200)));
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		queue_random(100);
		drain();

		write_limit(24'hFFFFFF);
		send_idle_pct  = 6;
		recv_stall_pct = 6;
		push_cmd(MODE_SET, 24'hFFFFFF, 1'b1, 16'h0F0F);
		push_cmd(MODE_CLEAR, 24'hFFFFFF, 1'b0, 16'h0000);
		push_cmd(MODE_SEARCH, 24'hFFFFFF, 1'b0, 16'h0000);
		push_cmd(MODE_RESTORE_ALL, 24'h000000, 1'b0, 16'h0000);
		queue_random(30);
		drain();

		write_limit(ADDR_W'($urandom_range(ADDR_MAX, 0)));
		queue_random(40);
		drain();

		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
